// ----- rtl/binary_max_heap_defines.svh -----
// ----------------------------------------------------------------------------
// Binary max heap assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_DEFINES_SVH
`define BINARY_MAX_HEAP_DEFINES_SVH

`ifndef SYNTHESIS

// Condition holds at every edge outside reset.
`define BMH_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("binary_max_heap: check failed");

// Consequent holds in the same cycle as the antecedent.
`define BMH_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("binary_max_heap: check failed");

// Consequent holds in the cycle after the antecedent.
`define BMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("binary_max_heap: check failed");

`else

`define BMH_ASSERT_ALWAYS(label, clk, rst, cond)
`define BMH_ASSERT_SAME(label, clk, rst, ante, cons)
`define BMH_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/bmh_pkg.sv -----
// ----------------------------------------------------------------------------
// Binary max heap package
// Word types, operation and status codes, controller/datapath bundles.
// ----------------------------------------------------------------------------
package bmh_pkg;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } req_word_t;

  typedef struct packed {
    logic signed [31:0] max_value;
    logic [1:0]         status;
    logic [6:0]         count;
  } rsp_word_t;

  // Controller to datapath commands, at most one step bit set at a time.
  typedef struct packed {
    logic start;
    logic up_rd;
    logic up_cmp;
    logic dn_last;
    logic dn_load;
    logic dn_rd;
    logic dn_cmp;
    logic fin;
    logic load_rsp;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic full;
    logic empty;
    logic one_left;
    logic up_go;
    logic up_top;
    logic dn_leaf;
    logic dn_move;
  } sts_t;

endpackage

// ----- rtl/bmh_stream_if.sv -----
// ----------------------------------------------------------------------------
// Binary max heap stream channel
// Valid/ready channel carrying one word of type word_t.
// ----------------------------------------------------------------------------
interface bmh_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/bmh_ram.sv -----
// ----------------------------------------------------------------------------
// Binary max heap RAM
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ----- rtl/bmh_ctrl.sv -----
// ----------------------------------------------------------------------------
// Binary max heap controller
// Sequences decode, sift up, sift down and result hand-off.
// ----------------------------------------------------------------------------
module bmh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic [1:0]    req_op,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  bmh_pkg::sts_t sts,
  output bmh_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_DN_LAST = 4'd3;
  localparam logic [3:0] S_DN_LOAD = 4'd4;
  localparam logic [3:0] S_DN_RD   = 4'd5;
  localparam logic [3:0] S_DN_CMP  = 4'd6;
  localparam logic [3:0] S_FIN     = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       rsp_free;

  assign req_ready = (state == S_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.start = 1'b1;
          if (req_op == bmh_pkg::OP_INSERT) begin
            if (sts.full) begin
              state_next = S_DONE;
            end else if (sts.empty) begin
              state_next = S_FIN;
            end else begin
              state_next = S_UP_RD;
            end
          end else if (req_op == bmh_pkg::OP_EXTRACT) begin
            if (sts.empty || sts.one_left) begin
              state_next = S_DONE;
            end else begin
              state_next = S_DN_LAST;
            end
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_UP_RD: begin
        cmd.up_rd  = 1'b1;
        state_next = S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd.up_cmp = 1'b1;
        if (sts.up_go && !sts.up_top) begin
          state_next = S_UP_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DN_LAST: begin
        cmd.dn_last = 1'b1;
        state_next  = S_DN_LOAD;
      end
      S_DN_LOAD: begin
        cmd.dn_load = 1'b1;
        state_next  = S_DN_RD;
      end
      S_DN_RD: begin
        cmd.dn_rd = 1'b1;
        if (sts.dn_leaf) begin
          state_next = S_FIN;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        cmd.dn_cmp = 1'b1;
        if (sts.dn_move) begin
          state_next = S_DN_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (rsp_free) begin
          cmd.load_rsp = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/bmh_dpath.sv -----
// ----------------------------------------------------------------------------
// Binary max heap datapath
// Entry count, root copy, moving key and slot, heap RAM, result register.
// ----------------------------------------------------------------------------
`include "binary_max_heap_defines.svh"

module bmh_dpath #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         req_op,
  input  logic signed [31:0] req_value,
  input  bmh_pkg::cmd_t      cmd,
  output bmh_pkg::sts_t      sts,
  output bmh_pkg::rsp_word_t rsp_word
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic [CW-1:0]              count;
  logic [CW-1:0]              pos;
  logic [CW:0]                lslot;
  logic [CW-1:0]              parent;
  logic signed [KEY_WIDTH-1:0] key;
  logic signed [KEY_WIDTH-1:0] cur;
  logic signed [KEY_WIDTH-1:0] root;
  logic signed [KEY_WIDTH-1:0] held_max;
  logic signed [KEY_WIDTH-1:0] rd0;
  logic signed [KEY_WIDTH-1:0] rd1;
  logic [KEY_WIDTH-1:0]        rdata0;
  logic [KEY_WIDTH-1:0]        rdata1;
  logic                        ext_r;
  logic [1:0]                  status_r;
  logic                        is_ins;
  logic                        is_ext;
  logic                        grow;
  logic                        shrink;
  logic                        has_r;
  logic                        left_gt;
  logic                        right_gt;
  logic signed [KEY_WIDTH-1:0] best_val;
  logic [CW-1:0]               best_slot;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [KEY_WIDTH-1:0]        wdata;
  logic [AW-1:0]               raddr0;
  logic [AW-1:0]               raddr1;

  assign key    = KEY_WIDTH'(req_value);
  assign is_ins = (req_op == bmh_pkg::OP_INSERT);
  assign is_ext = (req_op == bmh_pkg::OP_EXTRACT);
  assign grow   = cmd.start && is_ins && !sts.full;
  assign shrink = cmd.start && is_ext && !sts.empty;
  assign rd0    = rdata0;
  assign rd1    = rdata1;
  assign parent = pos >> 1;
  assign lslot  = {pos, 1'b0};

  // Child compare: left wins a tie, an equal key stops the sift.
  assign has_r    = lslot < (CW + 1)'(count);
  assign left_gt  = rd0 > cur;
  assign right_gt = has_r && (left_gt ? (rd1 > rd0) : (rd1 > cur));

  always_comb begin
    best_val  = cur;
    best_slot = pos;
    if (right_gt) begin
      best_val  = rd1;
      best_slot = CW'(lslot + (CW + 1)'(1));
    end else if (left_gt) begin
      best_val  = rd0;
      best_slot = CW'(lslot);
    end
  end

  assign sts.full     = (count == CW'(CAPACITY));
  assign sts.empty    = (count == '0);
  assign sts.one_left = (count == CW'(1));
  assign sts.up_go    = (cur > rd0);
  assign sts.up_top   = (parent == CW'(1));
  assign sts.dn_leaf  = (lslot > (CW + 1)'(count));
  assign sts.dn_move  = left_gt || right_gt;

  always_comb begin
    we     = 1'b0;
    waddr  = AW'(pos - CW'(1));
    wdata  = cur;
    raddr0 = '0;
    raddr1 = AW'(lslot);
    if (cmd.up_rd) begin
      raddr0 = AW'(parent - CW'(1));
    end else if (cmd.dn_rd) begin
      raddr0 = AW'(lslot - (CW + 1)'(1));
    end else if (cmd.dn_last) begin
      // fetch the last entry, the count already dropped by one
      raddr0 = AW'(count);
    end
    if (cmd.up_cmp && sts.up_go) begin
      we    = 1'b1;
      wdata = rd0;
    end else if (cmd.dn_cmp && sts.dn_move) begin
      we    = 1'b1;
      wdata = best_val;
    end else if (cmd.fin) begin
      we = 1'b1;
    end
  end

  bmh_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (grow) begin
      count <= count + CW'(1);
    end else if (shrink) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ext_r <= is_ext;
      if (is_ins && sts.full) begin
        status_r <= bmh_pkg::ST_FULL;
      end else if (!is_ins && sts.empty) begin
        status_r <= bmh_pkg::ST_EMPTY;
      end else begin
        status_r <= bmh_pkg::ST_OK;
      end
      held_max <= root;
      pos      <= count + CW'(1);
      cur      <= key;
    end
    if (cmd.up_cmp && sts.up_go) begin
      pos <= parent;
    end
    if (cmd.dn_load) begin
      cur <= rd0;
      pos <= CW'(1);
    end
    if (cmd.dn_cmp && sts.dn_move) begin
      pos <= best_slot;
      if (pos == CW'(1)) begin
        root <= best_val;
      end
    end
    if (cmd.fin && pos == CW'(1)) begin
      root <= cur;
    end
    if (cmd.load_rsp) begin
      if (status_r == bmh_pkg::ST_EMPTY) begin
        rsp_word.max_value <= '0;
      end else if (ext_r) begin
        rsp_word.max_value <= 32'(held_max);
      end else begin
        rsp_word.max_value <= 32'(root);
      end
      rsp_word.status <= status_r;
      rsp_word.count  <= 7'(count);
    end
  end

  `BMH_ASSERT_ALWAYS(a_count_range, clk, rst, count <= CW'(CAPACITY))
  `BMH_ASSERT_NEXT(a_insert_grows, clk, rst, grow, count == $past(count) + CW'(1))
  `BMH_ASSERT_NEXT(a_extract_shrinks, clk, rst, shrink, count == $past(count) - CW'(1))
  `BMH_ASSERT_SAME(a_empty_zero, clk, rst, cmd.load_rsp && status_r == bmh_pkg::ST_EMPTY, sts.empty)

endmodule

// ----- rtl/binary_max_heap.sv -----
// Peek, rejected ops and an extract of the last entry go straight to the result;
// an insert into an empty heap writes the key at once, else the key climbs level by
// level until it reaches the root or stops below, then is written; an extract moves
// the last entry to the root and sinks it level by level, reading both children.
// Throughput: one item at a time; an item holds the block until its result loads and the
// next word is taken after that. Reset: clears the count and handshake, not the RAM.
// ----------------------------------------------------------------------------
// Binary max heap
// Max priority queue over a one-based binary heap held in a RAM.
// ----------------------------------------------------------------------------
module binary_max_heap #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input logic          clk,
  input logic          rst,
  bmh_stream_if.sink   req,
  bmh_stream_if.source rsp
);

  // Command and status bundles between controller and datapath.
  bmh_pkg::cmd_t      cmd;
  bmh_pkg::sts_t      sts;
  bmh_pkg::rsp_word_t rsp_word;
  logic               req_ready;
  logic               rsp_valid;

  // Controller: takes one request word, walks the sift, hands off the result.
  bmh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.data.op),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: count, root copy, moving key, heap RAM and the output register.
  bmh_dpath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req_op    (req.data.op),
    .req_value (req.data.value),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_word  (rsp_word)
  );

  // Drive the channels; the output register frees the controller to accept
  // the next word while a result still waits.
  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_word;

endmodule

// ----- tb/sv/binary_max_heap_tb.sv -----
// ----------------------------------------------------------------------------
// Binary max heap testbench
// Drives insert, extract and peek words into the heap through the request
// stream and checks every response word against a shadow heap kept here.
// Covers the empty and full heap, extreme and tied keys, the unused op
// code, bursty requests, a stalling response side and one long response
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module binary_max_heap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1880;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AFTER = 600;
  localparam int DRAIN_CYCLES = 32;
  localparam int REPORT_MAX = 10;

  // Shadow copy of the heap: predicts the response to each accepted request
  // word and keeps the predicted responses in arrival order.
  class heap_shadow;
    logic signed [31:0]  keys [1:DEPTH];
    int                  fill;
    bmh_pkg::rsp_word_t  replies [$];
    int                  mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function void swap_keys(int a, int b);
      logic signed [31:0] t;
      t       = keys[a];
      keys[a] = keys[b];
      keys[b] = t;
    endfunction

    function void note_request(bmh_pkg::req_word_t w);
      bmh_pkg::rsp_word_t r;
      int                 pos;
      int                 best;
      int                 kid;
      r.status    = bmh_pkg::ST_OK;
      r.max_value = '0;
      if (w.op == bmh_pkg::OP_INSERT) begin
        if (fill >= DEPTH) begin
          r.status    = bmh_pkg::ST_FULL;
          r.max_value = keys[1];
        end else begin
          // place at the next free slot, climb while strictly larger
          fill++;
          keys[fill] = w.value;
          pos = fill;
          while (pos > 1 && keys[pos] > keys[pos / 2]) begin
            swap_keys(pos, pos / 2);
            pos = pos / 2;
          end
          r.max_value = keys[1];
        end
      end else if (fill == 0) begin
        r.status = bmh_pkg::ST_EMPTY;
      end else if (w.op == bmh_pkg::OP_EXTRACT) begin
        r.max_value = keys[1];
        keys[1] = keys[fill];
        fill--;
        // sink the moved key; left child wins a tie with the right
        pos = 1;
        while (1) begin
          best = pos;
          kid  = 2 * pos;
          if (kid <= fill && keys[kid] > keys[best]) best = kid;
          if (kid + 1 <= fill && keys[kid + 1] > keys[best]) best = kid + 1;
          if (best == pos) break;
          swap_keys(pos, best);
          pos = best;
        end
      end else begin
        // peek and the unused code both just read the root
        r.max_value = keys[1];
      end
      r.count = fill[6:0];
      replies = {replies, r};
    endfunction

    function void check_reply(bmh_pkg::rsp_word_t got);
      bmh_pkg::rsp_word_t want;
      if (replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected reply: max=%0d status=%0d count=%0d",
                   got.max_value, got.status, got.count);
        return;
      end
      want = replies.pop_front();
      if (got.max_value !== want.max_value || got.status !== want.status ||
          got.count !== want.count) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: want max=%0d st=%0d cnt=%0d, got max=%0d st=%0d cnt=%0d",
                   want.max_value, want.status, want.count,
                   got.max_value, got.status, got.count);
      end
    endfunction

    function int pending();
      return replies.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  bmh_stream_if #(.word_t(bmh_pkg::req_word_t)) req_ch ();
  bmh_stream_if #(.word_t(bmh_pkg::rsp_word_t)) rsp_ch ();

  heap_shadow         book = new();
  bmh_pkg::req_word_t plan [$];
  int                 accepted = 0;
  int                 cycles = 0;

  binary_max_heap #(
    .CAPACITY (DEPTH),
    .KEY_WIDTH(32)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bmh_pkg::req_word_t make_word(logic [1:0] op, logic [31:0] v);
    bmh_pkg::req_word_t w;
    w.op    = op;
    w.value = v;
    return w;
  endfunction

  // Append one request word to the plan.
  function automatic void add_word(logic [1:0] op, logic [31:0] v);
    plan = {plan, make_word(op, v)};
  endfunction

  // Keys: full range, right-shifted random, a narrow band for ties and both extremes.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 7)) inside
      [0:2]:   return $urandom;
      [3:4]:   return 32'($urandom_range(0, 15)) - 32'd8;
      5:       return 32'h7fff_ffff - 32'($urandom_range(0, 3));
      6:       return 32'h8000_0000 + 32'($urandom_range(0, 3));
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // Offer one request word and hold it until the block takes it.
  task automatic offer_word(input bmh_pkg::req_word_t w);
    req_ch.data  <= w;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    book.note_request(w);
    accepted++;
  endtask

  // Count cycles, bail out on a hung run, and check every response word.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (rst === 1'b0 && rsp_ch.valid && rsp_ch.ready) begin
      book.check_reply(rsp_ch.data);
    end
  end

  // Response side: stall on a pattern of its own, switching modes in
  // stretches. Once, mid-run, hold ready low long enough that the block
  // backs up and has to refuse new requests.
  initial begin
    int  mode;
    int  span;
    int  tick;
    bit  held;
    rsp_ch.ready <= 1'b0;
    tick = 0;
    held = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (!held && accepted >= HOLD_AFTER) begin
          held = 1'b1;
          rsp_ch.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end else begin
          case (mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_ch.ready <= (tick % 4 != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // Request side: directed words first, then random segments that lean
  // toward filling or draining so both the full and the empty heap show up.
  initial begin
    int seg_left;
    int ins_weight;
    int pick;
    int burst;
    int gap;
    logic [1:0] op;

    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    rst          <= 1'b1;

    // empty heap: every read-type op must flag empty
    add_word(bmh_pkg::OP_PEEK, $urandom);
    add_word(bmh_pkg::OP_EXTRACT, $urandom);
    add_word(OP_UNUSED, $urandom);
    // extract of the only entry, then extremes and ties
    add_word(bmh_pkg::OP_INSERT, 32'h8000_0000);
    add_word(bmh_pkg::OP_EXTRACT, $urandom);
    add_word(bmh_pkg::OP_INSERT, 32'h7fff_ffff);
    add_word(bmh_pkg::OP_INSERT, 32'h0000_0000);
    add_word(bmh_pkg::OP_INSERT, 32'hffff_ffff);
    add_word(bmh_pkg::OP_INSERT, 32'd5);
    add_word(bmh_pkg::OP_INSERT, 32'd5);
    add_word(bmh_pkg::OP_INSERT, 32'd5);
    add_word(bmh_pkg::OP_INSERT, 32'h8000_0000);
    add_word(bmh_pkg::OP_PEEK, $urandom);
    add_word(OP_UNUSED, $urandom);
    // drain to empty, then peek the empty heap
    repeat (7) add_word(bmh_pkg::OP_EXTRACT, $urandom);
    add_word(bmh_pkg::OP_PEEK, $urandom);

    // open with a long insert-heavy segment so the heap reaches full early
    seg_left   = 150;
    ins_weight = 92;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 220);
        case ($urandom_range(0, 3))
          0:       ins_weight = 92;
          1:       ins_weight = 55;
          2:       ins_weight = 12;
          default: ins_weight = 70;
        endcase
      end
      seg_left--;
      pick = $urandom_range(0, 99);
      if (pick < ins_weight) begin
        add_word(bmh_pkg::OP_INSERT, pick_key());
      end else begin
        pick = $urandom_range(0, 19);
        op = (pick < 14) ? bmh_pkg::OP_EXTRACT : (pick < 19) ? bmh_pkg::OP_PEEK : OP_UNUSED;
        add_word(op, $urandom);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // send in bursts; keep valid high across a burst, drop it for gaps
    while (plan.size() > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && plan.size() > 0) begin
        offer_word(plan.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_ch.valid <= 1'b0;

    // wait out the outstanding responses, then a little longer for strays
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (book.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- binary_max_heap.f -----
+incdir+rtl
rtl/bmh_pkg.sv
rtl/bmh_stream_if.sv
rtl/bmh_ram.sv
rtl/bmh_ctrl.sv
rtl/bmh_dpath.sv
rtl/binary_max_heap.sv
tb/sv/binary_max_heap_tb.sv
